### hdl/psch_pkg.sv
`timescale 1ns / 1ps

package psch_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] STAT_LOADED = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_RAN    = 3'd2;
  localparam logic [2:0] STAT_IDLE   = 3'd3;
  localparam logic [2:0] STAT_DONE   = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [15:0] proc_id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] run_id;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] wait_time;
  } out_item_t;

  // Packet that walks the cell chain during a tick
  typedef struct packed {
    logic        vld;
    logic        any_left;
    logic        found;
    logic [7:0]  prio;
    logic [15:0] id;
    logic [31:0] arrival;
    logic [15:0] burst;
    logic [15:0] rem;
  } sweep_t;

  typedef struct packed {
    logic loaded;
    logic is_cur;
    logic busy;
    logic load_we;
    logic dec_we;
    logic clr_rdy;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_e;

endpackage

### hdl/psch_cell.sv
`timescale 1ns / 1ps

module psch_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psch_pkg::cell_ctrl_t ctrl_i,
  input  logic [31:0]          now_i,
  input  psch_pkg::in_item_t   ld_i,
  input  psch_pkg::sweep_t     pk_i,
  input  logic [IW-1:0]        idx_i,
  output psch_pkg::sweep_t     pk_o,
  output logic [IW-1:0]        idx_o
);
  import psch_pkg::*;

  logic [15:0]   id_q;
  logic [31:0]   arr_q;
  logic [15:0]   burst_q;
  logic [15:0]   rem_q;
  logic [7:0]    prio_q;
  logic          ready_q;
  logic          vld_q;
  sweep_t        pk_q;
  sweep_t        pk_d;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] idx_d;
  logic          join_rdy;
  logic          rdy_new;
  logic          take;

  assign join_rdy = ctrl_i.loaded && (arr_q == now_i) && (rem_q != 16'd0);
  assign rdy_new  = ready_q || join_rdy;
  // when busy, only the running slot fills the lane; otherwise the best ready slot so far
  assign take = ctrl_i.busy ? ctrl_i.is_cur
                            : (rdy_new && (!pk_i.found || (prio_q < pk_i.prio)));

  always_comb begin
    pk_d          = pk_i;
    idx_d         = idx_i;
    pk_d.any_left = pk_i.any_left || (ctrl_i.loaded && (rem_q != 16'd0));
    if (take) begin
      pk_d.found   = 1'b1;
      pk_d.prio    = prio_q;
      pk_d.id      = id_q;
      pk_d.arrival = arr_q;
      pk_d.burst   = burst_q;
      pk_d.rem     = rem_q;
      idx_d        = IW'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= pk_i.vld;
      if (ctrl_i.load_we) begin
        ready_q <= 1'b0;
      end else if (pk_i.vld) begin
        ready_q <= rdy_new;
      end else if (ctrl_i.clr_rdy) begin
        ready_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_we) begin
      id_q    <= ld_i.proc_id;
      arr_q   <= ld_i.arrival;
      burst_q <= ld_i.burst;
      rem_q   <= ld_i.burst;
      prio_q  <= ld_i.prio;
    end else if (ctrl_i.dec_we) begin
      rem_q <= rem_q - 16'd1;
    end
    if (pk_i.vld) begin
      pk_q  <= pk_d;
      idx_q <= idx_d;
    end
  end

  always_comb begin
    pk_o     = pk_q;
    pk_o.vld = vld_q;
  end

  assign idx_o = idx_q;

endmodule

### hdl/nonpreemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  in_i  (cmd, proc_id, arrival, burst, prio)
// out      output     out_valid_o / out_stall_i out_o (status, run_id, finished,
//                                                      turnaround, wait_time)
//
// A load's result is registered in the cycle after its acceptance.
// In a tick, a packet walks the row of slot cells, one cell a cycle,
// gathering the ready join, the best priority and the running entry.
// One item is in flight at a time; the next is taken once the result is registered.
// Reset clears time, the table count and the ready flags; slot contents need none.
// A stalled output holds its item and holds off new input items.

module nonpreemptive_priority_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psch_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psch_pkg::out_item_t out_o
);
  import psch_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_e        state_q;
  state_e        state_d;
  logic [31:0]   now_q;
  logic [31:0]   now_d;
  logic          busy_q;
  logic          busy_d;
  logic [IW-1:0] cur_q;
  logic [IW-1:0] cur_d;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic          out_valid_q;
  out_item_t     out_q;
  out_item_t     res;
  logic          out_load;
  logic          out_free;
  logic          in_fire;
  logic          load_ok;
  logic          tick_fire;
  logic          fin;
  logic          commit_dec;
  logic          commit_clr;
  logic [15:0]   rem1;
  logic [31:0]   tat;

  sweep_t        pk  [SLOTS+1];
  logic [IW-1:0] idx [SLOTS+1];
  cell_ctrl_t    cctl[SLOTS];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign tick_fire  = in_fire && (in_i.cmd == CMD_TICK);
  assign load_ok    = in_fire && (in_i.cmd == CMD_LOAD) && (count_q != CW'(SLOTS));
  assign fin        = (state_q == S_FINISH) && out_free;

  always_comb begin
    pk[0]     = '0;
    pk[0].vld = tick_fire;
    idx[0]    = '0;
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    always_comb begin
      cctl[k].loaded  = CW'(k) < count_q;
      cctl[k].is_cur  = cur_q == IW'(k);
      cctl[k].busy    = busy_q;
      cctl[k].load_we = load_ok && (count_q == CW'(k));
      cctl[k].dec_we  = commit_dec && (idx[SLOTS] == IW'(k));
      cctl[k].clr_rdy = commit_clr && (idx[SLOTS] == IW'(k));
    end

    psch_cell #(
      .IDX(k),
      .IW (IW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cctl[k]),
      .now_i (now_q),
      .ld_i  (in_i),
      .pk_i  (pk[k]),
      .idx_i (idx[k]),
      .pk_o  (pk[k+1]),
      .idx_o (idx[k+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (tick_fire) state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (pk[SLOTS].vld) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res        = '0;
    out_load   = 1'b0;
    commit_dec = 1'b0;
    commit_clr = 1'b0;
    now_d      = now_q;
    busy_d     = busy_q;
    cur_d      = cur_q;
    count_d    = count_q;
    rem1       = pk[SLOTS].rem - 16'd1;
    tat        = now_q + 32'd1 - pk[SLOTS].arrival;
    if (in_fire && (in_i.cmd == CMD_LOAD)) begin
      out_load = 1'b1;
      if (load_ok) begin
        res.status = STAT_LOADED;
        count_d    = count_q + CW'(1);
      end else begin
        res.status = STAT_FULL;
      end
    end
    if (fin) begin
      out_load = 1'b1;
      if (!pk[SLOTS].any_left) begin
        res.status = STAT_DONE;
      end else begin
        now_d = now_q + 32'd1;
        if (!busy_q && !pk[SLOTS].found) begin
          res.status = STAT_IDLE;
        end else begin
          // serve the chosen or running slot for one tick
          cur_d      = idx[SLOTS];
          commit_clr = !busy_q;
          commit_dec = 1'b1;
          res.status = STAT_RAN;
          res.run_id = pk[SLOTS].id;
          if (rem1 == 16'd0) begin
            busy_d         = 1'b0;
            res.finished   = 1'b1;
            res.turnaround = tat;
            res.wait_time  = tat - {16'd0, pk[SLOTS].burst};
          end else begin
            busy_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= 32'd0;
      busy_q      <= 1'b0;
      cur_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      busy_q  <= busy_d;
      cur_q   <= cur_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("slot count beyond table size");

  a_busy_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (CW'(cur_q) < count_q))
    else $error("running slot not loaded");

  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pk[SLOTS].vld |-> (state_q == S_SWEEP))
    else $error("sweep packet outside sweep");

  a_now_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (now_q != $past(now_q)) |-> ((now_q == $past(now_q) + 32'd1) && $past(fin)))
    else $error("time moved other than by one finished tick");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(fin) || $past(in_fire && (in_i.cmd == CMD_LOAD))))
    else $error("result item without a source");

endmodule
